FILE: hw/rtl/tbp_pkg.sv
// shared types and constants of the two-level token-bucket policer
`default_nettype none

package tbp_pkg;

  // field widths
  localparam int CAP_W  = 32;
  localparam int TOK_W  = 48;
  localparam int TIME_W = 48;

  // parameter defaults
  localparam int UE_SLOTS_DEF      = 16;
  localparam int SESSION_SLOTS_DEF = 64;
  localparam int REFILL_MS_DEF     = 1000;
  localparam int TIME_BITS_DEF     = 48;

  // request opcodes
  localparam logic [1:0] OP_CHECK   = 2'd0;
  localparam logic [1:0] OP_SET_UE  = 2'd1;
  localparam logic [1:0] OP_SET_SES = 2'd2;

  // deny reasons
  localparam logic [1:0] DENY_NONE = 2'd0;
  localparam logic [1:0] DENY_UE   = 2'd1;
  localparam logic [1:0] DENY_SES  = 2'd2;

  // per-field write enables of the bucket memory
  typedef struct packed {
    logic cap;
    logic tok;
    logic last;
  } bucket_we_t;

endpackage

`default_nettype wire

FILE: hw/rtl/two_level_token_bucket_policer.sv
// two-level token-bucket policer: sequencer, datapath and bucket state
//
// usage
//   request channel: drive opcode_i, direction_i, ue_slot_i, session_slot_i,
//   amount_i and now_ms_i with start high; the request is taken on a rising
//   edge where busy is low. busy stays high until the request is finished.
//   result channel: done_o pulses for one cycle with allowed_o and
//   denied_by_o; the receiver cannot stall, the result is gone afterwards.
// sequencing
//   resize, remove, unknown opcode or slot out of range finish from dispatch;
//   create goes on through the create state. packet check visits each enabled
//   bucket (UE, then session) and skips an absent one; a UE drop ends it.
//   a new request can be taken in the cycle done_o is high. one request at a
//   time; the rate is set by the single shared multiplier and the
//   single-port bucket memory that each bucket check walks through (read,
//   full level, refill, debit).
// reset
//   rst_ni clears the sequencer and all bucket enable bits, so every bucket
//   starts absent; the bucket memory itself needs no clearing because an
//   entry is only read while its enable bit is set.
`default_nettype none

module two_level_token_bucket_policer import tbp_pkg::*; #(
  parameter int UE_SLOTS      = UE_SLOTS_DEF,
  parameter int SESSION_SLOTS = SESSION_SLOTS_DEF,
  parameter int REFILL_MS     = REFILL_MS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic        direction_i,
  input  wire logic [3:0]  ue_slot_i,
  input  wire logic [5:0]  session_slot_i,
  input  wire logic [31:0] amount_i,
  input  wire logic [47:0] now_ms_i,
  output logic             done_o,
  output logic             allowed_o,
  output logic [1:0]       denied_by_o
);

  // table geometry: per direction, UE buckets first, then session buckets
  localparam int BUCKETS = UE_SLOTS + SESSION_SLOTS;
  localparam int ND      = 2 * BUCKETS;
  localparam int AW      = $clog2(ND);
  // timestamps wrap at TIME_BITS, but never exceed the port width
  localparam int TW      = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  // elapsed times below the refill period fit in RW bits
  localparam int RW      = $clog2(REFILL_MS + 1);
  localparam int PW      = CAP_W + RW;

  localparam logic [RW-1:0] RMS = RW'(REFILL_MS);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_NEED     = 4'd2;
  localparam logic [3:0] S_BSEL     = 4'd3;
  localparam logic [3:0] S_RD       = 4'd4;
  localparam logic [3:0] S_MFULL    = 4'd5;
  localparam logic [3:0] S_MADD     = 4'd6;
  localparam logic [3:0] S_DEBIT    = 4'd7;
  localparam logic [3:0] S_CREATE   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       phase_q, phase_d;   // 0 UE bucket, 1 session bucket
  logic       done_q, done_d;
  logic       allowed_q, allowed_d;
  logic [1:0] denied_q, denied_d;
  logic [ND-1:0] en_q;

  // latched request
  logic [1:0]       op_q;
  logic             dir_q;
  logic [3:0]       ue_q;
  logic [5:0]       ses_q;
  logic [CAP_W-1:0] amt_q;
  logic [TW-1:0]    now_q;

  // per-bucket working registers
  logic [TOK_W-1:0] need_q;
  logic [CAP_W-1:0] cap_q;
  logic [TOK_W-1:0] tok_q;
  logic             refill_q;
  logic             big_q;
  logic [RW-1:0]    elap_q;
  logic [TOK_W-1:0] full_q;
  logic [TOK_W-1:0] t_q;

  // memory and multiplier hookup
  bucket_we_t       we;
  logic [CAP_W-1:0] rd_cap;
  logic [TOK_W-1:0] rd_tok;
  logic [TW-1:0]    rd_last;
  logic [TOK_W-1:0] wr_tok;
  logic [CAP_W-1:0] mul_a;
  logic [RW-1:0]    mul_b;
  logic [PW-1:0]    mul_p;
  logic [TOK_W-1:0] prod;

  logic             ue_ok, ses_ok, use_ses, slot_ok, active;
  logic [31:0]      idx;
  logic [AW-1:0]    addr;
  logic [TW-1:0]    elapsed;
  logic             refill;
  logic [TOK_W:0]   sum;
  logic [TOK_W-1:0] clipped, t_new;
  logic [TOK_W:0]   diff;
  logic             short;
  logic             en_set, en_clr;

  // slot range checks and entry address
  assign ue_ok   = 32'(ue_q) < 32'(UE_SLOTS);
  assign ses_ok  = 32'(ses_q) < 32'(SESSION_SLOTS);
  assign use_ses = (op_q == OP_SET_SES) || ((op_q == OP_CHECK) && phase_q);
  assign slot_ok = use_ses ? ses_ok : ue_ok;
  assign idx     = (dir_q ? 32'(BUCKETS) : 32'd0)
                 + (use_ses ? 32'(UE_SLOTS) + 32'(ses_q) : 32'(ue_q));
  assign addr    = idx[AW-1:0];
  assign active  = slot_ok && en_q[addr];

  // time since last refill, only meaningful when time moved forward
  assign elapsed = now_q - rd_last;
  assign refill  = now_q > rd_last;

  // operand select of the shared multiplier
  always_comb begin
    case (state_q)
      S_RD: begin
        mul_a = rd_cap;
        mul_b = RMS;
      end
      S_MFULL: begin
        mul_a = cap_q;
        mul_b = elap_q;
      end
      default: begin
        mul_a = amt_q;
        mul_b = RMS;
      end
    endcase
  end

  assign prod = TOK_W'(mul_p);

  // refill: add elapsed * capacity, capped at full level
  assign sum     = {1'b0, tok_q} + {1'b0, prod};
  assign clipped = (sum > {1'b0, full_q}) ? full_q : sum[TOK_W-1:0];
  assign t_new   = !refill_q ? tok_q : (big_q ? full_q : clipped);

  // debit: the borrow tells whether enough tokens remain
  assign diff  = {1'b0, t_q} - {1'b0, need_q};
  assign short = diff[TOK_W];

  assign wr_tok = (state_q == S_CREATE) ? prod : (short ? t_q : diff[TOK_W-1:0]);

  // sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    done_d    = 1'b0;
    allowed_d = allowed_q;
    denied_d  = denied_q;
    we        = '0;
    en_set    = 1'b0;
    en_clr    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DISPATCH;
          phase_d = 1'b0;
        end
      end
      S_DISPATCH: begin
        case (op_q)
          OP_CHECK: begin
            state_d = S_NEED;
          end
          OP_SET_UE, OP_SET_SES: begin
            if (!slot_ok) begin
              state_d   = S_IDLE;
              done_d    = 1'b1;
              allowed_d = 1'b1;
              denied_d  = DENY_NONE;
            end else if (amt_q == '0) begin
              // zero limit removes the bucket
              en_clr    = 1'b1;
              state_d   = S_IDLE;
              done_d    = 1'b1;
              allowed_d = 1'b1;
              denied_d  = DENY_NONE;
            end else if (en_q[addr]) begin
              // resize: tokens and timestamp kept
              we.cap    = 1'b1;
              state_d   = S_IDLE;
              done_d    = 1'b1;
              allowed_d = 1'b1;
              denied_d  = DENY_NONE;
            end else begin
              state_d = S_CREATE;
            end
          end
          default: begin
            state_d   = S_IDLE;
            done_d    = 1'b1;
            allowed_d = 1'b0;
            denied_d  = DENY_NONE;
          end
        endcase
      end
      S_NEED: begin
        state_d = S_BSEL;
      end
      S_BSEL: begin
        if (active) begin
          state_d = S_RD;
        end else if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          allowed_d = 1'b1;
          denied_d  = DENY_NONE;
        end
      end
      S_RD: begin
        state_d = S_MFULL;
      end
      S_MFULL: begin
        state_d = S_MADD;
      end
      S_MADD: begin
        state_d = S_DEBIT;
      end
      S_DEBIT: begin
        // refill is kept even when the debit fails
        we.tok  = 1'b1;
        we.last = refill_q;
        if (short) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          allowed_d = 1'b0;
          denied_d  = phase_q ? DENY_SES : DENY_UE;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          state_d = S_BSEL;
        end else begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          allowed_d = 1'b1;
          denied_d  = DENY_NONE;
        end
      end
      S_CREATE: begin
        // new bucket starts full
        we.cap    = 1'b1;
        we.tok    = 1'b1;
        we.last   = 1'b1;
        en_set    = 1'b1;
        state_d   = S_IDLE;
        done_d    = 1'b1;
        allowed_d = 1'b1;
        denied_d  = DENY_NONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      en_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      if (en_set) begin
        en_q[addr] <= 1'b1;
      end
      if (en_clr) begin
        en_q[addr] <= 1'b0;
      end
    end
  end

  // result and datapath registers
  always_ff @(posedge clk_i) begin
    allowed_q <= allowed_d;
    denied_q  <= denied_d;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_q  <= opcode_i;
          dir_q <= direction_i;
          ue_q  <= ue_slot_i;
          ses_q <= session_slot_i;
          amt_q <= amount_i;
          now_q <= now_ms_i[TW-1:0];
        end
      end
      S_NEED: begin
        need_q <= prod;
      end
      S_RD: begin
        cap_q    <= rd_cap;
        tok_q    <= rd_tok;
        refill_q <= refill;
        big_q    <= elapsed >= TW'(REFILL_MS);
        elap_q   <= elapsed[RW-1:0];
      end
      S_MFULL: begin
        full_q <= prod;
      end
      S_MADD: begin
        t_q <= t_new;
      end
      default: begin
      end
    endcase
  end

  tbp_mul_unit #(
    .RW (RW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  tbp_bucket_mem #(
    .DEPTH (ND),
    .AW    (AW),
    .TW    (TW)
  ) u_mem (
    .clk_i   (clk_i),
    .addr_i  (addr),
    .we_i    (we),
    .wcap_i  (amt_q),
    .wtok_i  (wr_tok),
    .wlast_i (now_q),
    .rcap_o  (rd_cap),
    .rtok_o  (rd_tok),
    .rlast_o (rd_last)
  );

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign allowed_o   = allowed_q;
  assign denied_by_o = denied_q;

  // a result only shows once the sequencer is back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // a passing result carries no deny reason
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && allowed_o) |-> (denied_by_o == DENY_NONE))
    else $error("allowed result with deny reason");

endmodule

`default_nettype wire

FILE: hw/rtl/tbp_mul_unit.sv
// shared registered multiplier, capacity or size by a refill-range operand
`default_nettype none

module tbp_mul_unit import tbp_pkg::*; #(
  parameter int RW = 10
) (
  input  wire logic                clk_i,
  input  wire logic [CAP_W-1:0]    a_i,
  input  wire logic [RW-1:0]       b_i,
  output logic      [CAP_W+RW-1:0] p_o
);

  logic [CAP_W+RW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (CAP_W+RW)'(a_i) * (CAP_W+RW)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tbp_bucket_mem.sv
// bucket memory: capacity, scaled tokens and last refill time per entry
`default_nettype none

module tbp_bucket_mem import tbp_pkg::*; #(
  parameter int DEPTH = 160,
  parameter int AW    = 8,
  parameter int TW    = 48
) (
  input  wire logic             clk_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire bucket_we_t       we_i,
  input  wire logic [CAP_W-1:0] wcap_i,
  input  wire logic [TOK_W-1:0] wtok_i,
  input  wire logic [TW-1:0]    wlast_i,
  output logic      [CAP_W-1:0] rcap_o,
  output logic      [TOK_W-1:0] rtok_o,
  output logic      [TW-1:0]    rlast_o
);

  logic [CAP_W-1:0] cap_mem  [DEPTH];
  logic [TOK_W-1:0] tok_mem  [DEPTH];
  logic [TW-1:0]    last_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.cap) begin
      cap_mem[addr_i] <= wcap_i;
    end
    if (we_i.tok) begin
      tok_mem[addr_i] <= wtok_i;
    end
    if (we_i.last) begin
      last_mem[addr_i] <= wlast_i;
    end
    rcap_o  <= cap_mem[addr_i];
    rtok_o  <= tok_mem[addr_i];
    rlast_o <= last_mem[addr_i];
  end

endmodule

`default_nettype wire
